// ----- design/tqpr_pkg.sv -----
// Package for the two-queue page replacement tracker.
// Holds the state machine type, command and result codes, and register indexes.
// Used by every module under design/.
`timescale 1ns / 1ps
package tqpr_pkg;

  localparam int PageW = 31;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_HIT_FREQ   = 3'd0,
    KIND_HIT_RECENT = 3'd1,
    KIND_MISS_FREQ  = 3'd2,
    KIND_MISS_REC   = 3'd3,
    KIND_BYPASS     = 3'd4,
    KIND_WRITEBACK  = 3'd5,
    KIND_FLUSH_DONE = 3'd6,
    KIND_UNUSED     = 3'd7
  } kind_t;

  localparam logic [1:0] REG_FREQ_CAP   = 2'd0;
  localparam logic [1:0] REG_RECENT_CAP = 2'd1;
  localparam logic [1:0] REG_GHOST_CAP  = 2'd2;
  localparam logic [1:0] REG_BYPASS     = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_EMIT_WB,
    ST_EMIT_ACC,
    ST_FLUSH_FREQ,
    ST_FLUSH_REC,
    ST_FLUSH_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture incoming word
    logic lookup;      // register match results
    logic hit_freq;    // move hit page to MRU
    logic hit_rec;     // mark recent hit dirty on write
    logic ins_freq;    // insert to frequent (evict when full)
    logic ins_rec;     // insert to recent (evict to ghost when full)
    logic flush_clr;   // clear both page lists
    logic scan_step;   // advance flush scan pointer
    logic scan_start;  // reset flush scan pointer
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic freq_hit;
    logic rec_hit;
    logic ghost_hit;
    logic freq_full;
    logic rec_full;
    logic freq_victim_dirty;
    logic rec_victim_dirty;
    logic scan_freq_end;
    logic scan_rec_end;
    logic scan_freq_dirty;
    logic scan_rec_dirty;
  } dp_status_t;

endpackage

// ----- design/tqpr_ctrl.sv -----
// Controller state machine for the two-queue page replacement tracker.
// Depends on tqpr_pkg; drives commands to tqpr_datapath, output handshake.
`timescale 1ns / 1ps
module tqpr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            in_command,
  input  logic                  bypass,
  input  logic                  out_stall,
  input  tqpr_pkg::dp_status_t  status,
  output tqpr_pkg::dp_cmd_t     cmd,
  output logic                  in_stall,
  output logic                  out_valid,
  output logic [2:0]            out_kind,
  output logic [1:0]            out_src,   // 0 access page, 1 freq victim/scan, 2 rec
  output logic                  out_last
);
  import tqpr_pkg::*;

  state_t state, state_next;
  cmd_t   op, op_next;
  kind_t  acc_kind, acc_kind_next;
  logic   wb_rec, wb_rec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op       <= CMD_READ;
      acc_kind <= KIND_HIT_FREQ;
      wb_rec   <= 1'b0;
    end else begin
      state    <= state_next;
      op       <= op_next;
      acc_kind <= acc_kind_next;
      wb_rec   <= wb_rec_next;
    end
  end

  logic wr;
  assign wr = (op == CMD_WRITE);

  always_comb begin
    state_next    = state;
    op_next       = op;
    acc_kind_next = acc_kind;
    wb_rec_next   = wb_rec;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    out_kind      = KIND_HIT_FREQ;
    out_src       = 2'd0;
    out_last      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load       = 1'b1;
          // scan back at slot 0 so eviction victims read from the head
          cmd.scan_start = 1'b1;
          op_next        = cmd_t'(in_command);
          unique case (cmd_t'(in_command))
            CMD_FLUSH: begin
              state_next     = ST_FLUSH_FREQ;
            end
            CMD_NONE: state_next = ST_IDLE;
            default:  state_next = ST_LOOKUP;
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        wb_rec_next = 1'b0;
        state_next  = ST_EMIT_ACC;
        if (wr && bypass) begin
          acc_kind_next = KIND_BYPASS;
        end else if (status.freq_hit) begin
          acc_kind_next = KIND_HIT_FREQ;
          cmd.hit_freq  = 1'b1;
        end else if (status.rec_hit) begin
          acc_kind_next = KIND_HIT_RECENT;
          cmd.hit_rec   = 1'b1;
        end else if (bypass) begin
          acc_kind_next = KIND_BYPASS;
        end else if (status.ghost_hit) begin
          acc_kind_next = KIND_MISS_FREQ;
          if (status.freq_full && status.freq_victim_dirty) begin
            state_next = ST_EMIT_WB;
          end else begin
            cmd.ins_freq = 1'b1;
          end
        end else begin
          acc_kind_next = KIND_MISS_REC;
          if (status.rec_full && status.rec_victim_dirty) begin
            wb_rec_next = 1'b1;
            state_next  = ST_EMIT_WB;
          end else begin
            cmd.ins_rec = 1'b1;
          end
        end
      end
      ST_EMIT_WB: begin
        // victim still at slot 0 until the insert fires
        out_valid = 1'b1;
        out_kind  = KIND_WRITEBACK;
        out_src   = wb_rec ? 2'd2 : 2'd1;
        if (!out_stall) begin
          cmd.ins_freq = !wb_rec;
          cmd.ins_rec  = wb_rec;
          state_next   = ST_EMIT_ACC;
        end
      end
      ST_EMIT_ACC: begin
        out_valid = 1'b1;
        out_kind  = acc_kind;
        out_last  = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      ST_FLUSH_FREQ: begin
        if (status.scan_freq_end) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_FLUSH_REC;
        end else if (status.scan_freq_dirty) begin
          out_valid = 1'b1;
          out_kind  = KIND_WRITEBACK;
          out_src   = 2'd1;
          if (!out_stall) cmd.scan_step = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FLUSH_REC: begin
        if (status.scan_rec_end) begin
          state_next = ST_FLUSH_DONE;
        end else if (status.scan_rec_dirty) begin
          out_valid = 1'b1;
          out_kind  = KIND_WRITEBACK;
          out_src   = 2'd2;
          if (!out_stall) cmd.scan_step = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FLUSH_DONE: begin
        out_valid = 1'b1;
        out_kind  = KIND_FLUSH_DONE;
        out_src   = 2'd3;
        out_last  = 1'b1;
        if (!out_stall) begin
          cmd.flush_clr = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ----- design/tqpr_datapath.sv -----
// Datapath of the two-queue page replacement tracker: three page lists
// held as shift registers, match vectors, and the flush scan pointer.
// Depends on tqpr_pkg.
`timescale 1ns / 1ps
module tqpr_datapath #(
  parameter int FREQUENT_DEPTH = 16,
  parameter int RECENT_DEPTH   = 16,
  parameter int GHOST_DEPTH    = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tqpr_pkg::dp_cmd_t          cmd,
  input  logic [1:0]                 in_command,
  input  logic [tqpr_pkg::PageW-1:0] in_page,
  input  logic [4:0]                 freq_cap,
  input  logic [4:0]                 rec_cap,
  input  logic [5:0]                 ghost_cap,
  input  logic [1:0]                 out_src,
  output tqpr_pkg::dp_status_t       status,
  output logic [tqpr_pkg::PageW-1:0] out_page
);
  import tqpr_pkg::*;

  localparam int FCW = $clog2(FREQUENT_DEPTH + 1);
  localparam int RCW = $clog2(RECENT_DEPTH + 1);
  localparam int GCW = $clog2(GHOST_DEPTH + 1);
  localparam int SCW = (FCW > RCW) ? FCW : RCW;
  // slot index widths
  localparam int FIW = (FREQUENT_DEPTH > 1) ? $clog2(FREQUENT_DEPTH) : 1;
  localparam int RIW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;

  logic [PageW-1:0] page;
  logic             wr;
  logic [PageW-1:0] fpg [FREQUENT_DEPTH];
  logic [FREQUENT_DEPTH-1:0] fdt;
  logic [FCW-1:0]   fcnt;
  logic [PageW-1:0] rpg [RECENT_DEPTH];
  logic [RECENT_DEPTH-1:0] rdt;
  logic [RCW-1:0]   rcnt;
  logic [PageW-1:0] gpg [GHOST_DEPTH];
  logic [GCW-1:0]   gcnt;
  logic [SCW-1:0]   scan;

  // registered match vectors
  logic [FREQUENT_DEPTH-1:0] fmatch;
  logic [RECENT_DEPTH-1:0]   rmatch;
  logic                      ghit;

  // clamped capacities
  logic [FCW-1:0] fcap;
  logic [RCW-1:0] rcap;
  logic [GCW-1:0] gcap;
  always_comb begin
    fcap = (freq_cap == 5'd0) ? FCW'(1) :
           ({27'd0, freq_cap} > 32'(FREQUENT_DEPTH)) ? FCW'(FREQUENT_DEPTH) : FCW'(freq_cap);
    rcap = (rec_cap == 5'd0) ? RCW'(1) :
           ({27'd0, rec_cap} > 32'(RECENT_DEPTH)) ? RCW'(RECENT_DEPTH) : RCW'(rec_cap);
    gcap = (ghost_cap == 6'd0) ? GCW'(1) :
           ({26'd0, ghost_cap} > 32'(GHOST_DEPTH)) ? GCW'(GHOST_DEPTH) : GCW'(ghost_cap);
  end

  logic freq_full, rec_full, ghost_full;
  assign freq_full  = (fcnt >= fcap);
  assign rec_full   = (rcnt >= rcap);
  assign ghost_full = (gcnt >= gcap);

  // hit position index (one-hot to binary)
  logic [FCW-1:0] fhit_idx;
  logic [RCW-1:0] rhit_idx;
  always_comb begin
    fhit_idx = '0;
    for (int i = 0; i < FREQUENT_DEPTH; i++) if (fmatch[i]) fhit_idx = FCW'(i);
    rhit_idx = '0;
    for (int i = 0; i < RECENT_DEPTH; i++) if (rmatch[i]) rhit_idx = RCW'(i);
  end

  // capture and lookup
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page <= in_page;
      wr   <= (in_command == CMD_WRITE);
    end
    if (cmd.lookup) begin
      for (int i = 0; i < FREQUENT_DEPTH; i++)
        fmatch[i] <= (FCW'(i) < fcnt) && (fpg[i] == page);
      for (int i = 0; i < RECENT_DEPTH; i++)
        rmatch[i] <= (RCW'(i) < rcnt) && (rpg[i] == page);
      ghit <= 1'b0;
      for (int i = 0; i < GHOST_DEPTH; i++)
        if ((GCW'(i) < gcnt) && (gpg[i] == page)) ghit <= 1'b1;
    end
  end

  // frequent list
  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= '0;
      fdt  <= '0;
    end else if (cmd.flush_clr) begin
      fcnt <= '0;
      fdt  <= '0;
    end else if (cmd.hit_freq) begin
      for (int i = 0; i < FREQUENT_DEPTH; i++) begin
        if (FCW'(i) >= fhit_idx && FCW'(i) + FCW'(1) < fcnt && i + 1 < FREQUENT_DEPTH) begin
          fpg[i] <= fpg[(i + 1) % FREQUENT_DEPTH];
          fdt[i] <= fdt[(i + 1) % FREQUENT_DEPTH];
        end else if (FCW'(i) + FCW'(1) == fcnt) begin
          fpg[i] <= page;
          fdt[i] <= fdt[fhit_idx[FIW-1:0]] | wr;
        end
      end
    end else if (cmd.ins_freq) begin
      if (freq_full && fcnt != '0) begin
        // shift out oldest, append at fcnt-1
        for (int i = 0; i < FREQUENT_DEPTH; i++) begin
          if (FCW'(i) + FCW'(1) < fcnt && i + 1 < FREQUENT_DEPTH) begin
            fpg[i] <= fpg[(i + 1) % FREQUENT_DEPTH];
            fdt[i] <= fdt[(i + 1) % FREQUENT_DEPTH];
          end else if (FCW'(i) + FCW'(1) == fcnt) begin
            fpg[i] <= page;
            fdt[i] <= wr;
          end
        end
      end else begin
        for (int i = 0; i < FREQUENT_DEPTH; i++)
          if (FCW'(i) == fcnt) begin
            fpg[i] <= page;
            fdt[i] <= wr;
          end
        fcnt <= fcnt + FCW'(1);
      end
    end
  end

  // recent list and ghost FIFO
  logic ghost_push;
  assign ghost_push = cmd.ins_rec && rec_full && (rcnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
      rdt  <= '0;
    end else if (cmd.flush_clr) begin
      rcnt <= '0;
      rdt  <= '0;
    end else if (cmd.hit_rec) begin
      if (wr) rdt[rhit_idx[RIW-1:0]] <= 1'b1;
    end else if (cmd.ins_rec) begin
      if (ghost_push) begin
        for (int i = 0; i < RECENT_DEPTH; i++) begin
          if (RCW'(i) + RCW'(1) < rcnt && i + 1 < RECENT_DEPTH) begin
            rpg[i] <= rpg[(i + 1) % RECENT_DEPTH];
            rdt[i] <= rdt[(i + 1) % RECENT_DEPTH];
          end else if (RCW'(i) + RCW'(1) == rcnt) begin
            rpg[i] <= page;
            rdt[i] <= wr;
          end
        end
      end else begin
        for (int i = 0; i < RECENT_DEPTH; i++)
          if (RCW'(i) == rcnt) begin
            rpg[i] <= page;
            rdt[i] <= wr;
          end
        rcnt <= rcnt + RCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gcnt <= '0;
    end else if (ghost_push) begin
      if (ghost_full && gcnt != '0) begin
        for (int i = 0; i < GHOST_DEPTH; i++) begin
          if (GCW'(i) + GCW'(1) < gcnt && i + 1 < GHOST_DEPTH)
            gpg[i] <= gpg[(i + 1) % GHOST_DEPTH];
          else if (GCW'(i) + GCW'(1) == gcnt)
            gpg[i] <= rpg[0];
        end
      end else begin
        for (int i = 0; i < GHOST_DEPTH; i++)
          if (GCW'(i) == gcnt) gpg[i] <= rpg[0];
        gcnt <= gcnt + GCW'(1);
      end
    end
  end

  // flush scan pointer
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) scan <= '0;
    else if (cmd.scan_step)    scan <= scan + SCW'(1);
  end

  logic [FIW-1:0] fsi;
  logic [RIW-1:0] rsi;
  assign fsi = scan[FIW-1:0];
  assign rsi = scan[RIW-1:0];

  always_comb begin
    status.freq_hit          = |fmatch;
    status.rec_hit           = |rmatch;
    status.ghost_hit         = ghit;
    status.freq_full         = freq_full && (fcnt != '0);
    status.rec_full          = rec_full && (rcnt != '0);
    status.freq_victim_dirty = fdt[0];
    status.rec_victim_dirty  = rdt[0];
    status.scan_freq_end     = (SCW'(fcnt) <= scan);
    status.scan_rec_end      = (SCW'(rcnt) <= scan);
    status.scan_freq_dirty   = fdt[fsi];
    status.scan_rec_dirty    = rdt[rsi];
    case (out_src)
      2'd0:    out_page = page;
      2'd1:    out_page = (scan == '0) ? fpg[0] : fpg[fsi];
      2'd2:    out_page = (scan == '0) ? rpg[0] : rpg[rsi];
      default: out_page = '0;
    endcase
  end
endmodule

// ----- design/two_queue_page_replacement.sv -----
// Top level of the two-queue (2Q) page replacement tracker.
// Depends on tqpr_pkg, tqpr_ctrl and tqpr_datapath; holds the APB registers.
`timescale 1ns / 1ps
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ---------------------------
//  input     in         in_valid/in_stall    command, page_id
//  output    out        out_valid/out_stall  kind, result_page, last
//  config    APB        psel/penable/pready  paddr, pwdata, prdata
//
// A read or write word passes through accept, lookup (compare over all
// three lists), decide, a write-back emit when a dirty victim is evicted,
// and emit; the lookup match results are registered. A flush walks the
// frequent then recent list, one slot a cycle unless a write-back stalls.
// Reset empties all lists and restores register defaults. Output stalls hold
// the controller in its emit state; no input word is taken until the last
// result of the current word is taken.
module two_queue_page_replacement #(
  parameter int FREQUENT_DEPTH = 16,
  parameter int RECENT_DEPTH   = 16,
  parameter int GHOST_DEPTH    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [30:0] page_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [30:0] result_page,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tqpr_pkg::*;

  logic [4:0] frequent_capacity, recent_capacity;
  logic [5:0] ghost_capacity;
  logic       bypass_mode;

  assign pready = 1'b1;

  logic [1:0] reg_idx;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      frequent_capacity <= 5'd16;
      recent_capacity   <= 5'd16;
      ghost_capacity    <= 6'd32;
      bypass_mode       <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_FREQ_CAP:   frequent_capacity <= pwdata[4:0];
        REG_RECENT_CAP: recent_capacity   <= pwdata[4:0];
        REG_GHOST_CAP:  ghost_capacity    <= pwdata[5:0];
        REG_BYPASS:     bypass_mode       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FREQ_CAP:   prdata = {27'd0, frequent_capacity};
      REG_RECENT_CAP: prdata = {27'd0, recent_capacity};
      REG_GHOST_CAP:  prdata = {26'd0, ghost_capacity};
      REG_BYPASS:     prdata = {31'd0, bypass_mode};
      default:        prdata = '0;
    endcase
  end

  dp_cmd_t    dcmd;
  dp_status_t dstat;
  logic [1:0] out_src;

  tqpr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (command),
    .bypass     (bypass_mode),
    .out_stall  (out_stall),
    .status     (dstat),
    .cmd        (dcmd),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_kind   (kind),
    .out_src    (out_src),
    .out_last   (last)
  );

  tqpr_datapath #(
    .FREQUENT_DEPTH (FREQUENT_DEPTH),
    .RECENT_DEPTH   (RECENT_DEPTH),
    .GHOST_DEPTH    (GHOST_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dcmd),
    .in_command (command),
    .in_page    (page_id),
    .freq_cap   (frequent_capacity),
    .rec_cap    (recent_capacity),
    .ghost_cap  (ghost_capacity),
    .out_src    (out_src),
    .status     (dstat),
    .out_page   (result_page)
  );

  // a word is never taken while results of the previous one are pending
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during output");

  // a flush-done result always carries page zero and closes the word
  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_FLUSH_DONE) |-> (last && result_page == '0))
    else $error("bad flush done");

  // write-back results are never final
  a_wb_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_WRITEBACK) |-> !last) else $error("write-back marked last");

endmodule
